// ----- rtl/fdpe_pkg.sv -----
// Shared constants and types for the fractional divider parameter encoder.
package fdpe_pkg;

  localparam int WHOLE_W = 11;
  localparam int FRAC_W  = 20;
  localparam int QUO_W   = 7;
  localparam int P1_W    = 18;
  localparam int OFS_W   = 3;
  localparam int BYTE_W  = 8;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;

  localparam logic [WHOLE_W-1:0] MIN_WHOLE = 11'd4;
  localparam logic [P1_W-1:0]    P1_BIAS   = 18'd512;

  // Register offsets within the eight-byte parameter block.
  localparam logic [OFS_W-1:0] OFS_P3_HI  = 3'd0;
  localparam logic [OFS_W-1:0] OFS_P3_LO  = 3'd1;
  localparam logic [OFS_W-1:0] OFS_P1_TOP = 3'd2;
  localparam logic [OFS_W-1:0] OFS_P1_MID = 3'd3;
  localparam logic [OFS_W-1:0] OFS_P1_LO  = 3'd4;
  localparam logic [OFS_W-1:0] OFS_NIBBLE = 3'd5;
  localparam logic [OFS_W-1:0] OFS_P2_MID = 3'd6;
  localparam logic [OFS_W-1:0] OFS_P2_LO  = 3'd7;

  // One entry of the divider chain: partial remainder and quotient so far.
  typedef struct packed {
    logic               valid;
    logic               bad;
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  den;
    logic [FRAC_W-1:0]  rem;
    logic [QUO_W-1:0]   quo;
  } div_stage_t;

endpackage

// ----- rtl/fdpe_div_cell.sv -----
// One restoring-division cell: develops one quotient bit of 128*b/c.
module fdpe_div_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  fdpe_pkg::div_stage_t  stage_in,
  output fdpe_pkg::div_stage_t  stage_out
);

  logic [fdpe_pkg::FRAC_W:0]   shifted;
  logic                        ge;
  logic [fdpe_pkg::FRAC_W:0]   diff;
  fdpe_pkg::div_stage_t        stage_next;

  assign shifted = {stage_in.rem, 1'b0};
  assign ge      = shifted >= {1'b0, stage_in.den};
  assign diff    = shifted - {1'b0, stage_in.den};

  always_comb begin
    stage_next     = stage_in;
    stage_next.rem = ge ? diff[fdpe_pkg::FRAC_W-1:0] : shifted[fdpe_pkg::FRAC_W-1:0];
    stage_next.quo = {stage_in.quo[fdpe_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (en) begin
      stage_out.valid <= stage_next.valid;
    end
    if (en) begin
      stage_out.bad   <= stage_next.bad;
      stage_out.whole <= stage_next.whole;
      stage_out.den   <= stage_next.den;
      stage_out.rem   <= stage_next.rem;
      stage_out.quo   <= stage_next.quo;
    end
  end

endmodule

// ----- rtl/fdpe_serializer.sv -----
// Forms P1, P2 and P3 and sends the parameter block out one byte per transaction.
module fdpe_serializer (
  input  logic                                clk,
  input  logic                                rst,
  input  fdpe_pkg::div_stage_t                stage_in,
  output logic                                in_ready,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fdpe_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tlast,
  output logic                                m_tuser
);

  logic                          busy;
  logic [fdpe_pkg::OFS_W-1:0]    idx;
  logic                          bad;
  logic [fdpe_pkg::P1_W-1:0]     p1;
  logic [fdpe_pkg::FRAC_W-1:0]   p2;
  logic [fdpe_pkg::FRAC_W-1:0]   p3;
  logic [fdpe_pkg::P1_W-1:0]     p1_next;
  logic [fdpe_pkg::BYTE_W-1:0]   byte_sel;
  logic                          at_last;
  logic                          load;

  assign at_last  = idx == fdpe_pkg::OFS_P2_LO;
  assign in_ready = !busy || (m_tready && at_last);
  assign load     = in_ready && stage_in.valid;
  // 128*a + q is just a and q side by side.
  assign p1_next  = {stage_in.whole, stage_in.quo} - fdpe_pkg::P1_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= fdpe_pkg::OFS_P3_HI;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= fdpe_pkg::OFS_P3_HI;
    end else if (busy && m_tready) begin
      busy <= !at_last;
      idx  <= idx + 3'd1;
    end
    if (load) begin
      bad <= stage_in.bad;
      p1  <= p1_next;
      p2  <= stage_in.rem;
      p3  <= stage_in.den;
    end
  end

  always_comb begin
    case (idx)
      fdpe_pkg::OFS_P3_HI:  byte_sel = p3[15:8];
      fdpe_pkg::OFS_P3_LO:  byte_sel = p3[7:0];
      fdpe_pkg::OFS_P1_TOP: byte_sel = {6'd0, p1[17:16]};
      fdpe_pkg::OFS_P1_MID: byte_sel = p1[15:8];
      fdpe_pkg::OFS_P1_LO:  byte_sel = p1[7:0];
      fdpe_pkg::OFS_NIBBLE: byte_sel = {p3[19:16], p2[19:16]};
      fdpe_pkg::OFS_P2_MID: byte_sel = p2[15:8];
      fdpe_pkg::OFS_P2_LO:  byte_sel = p2[7:0];
      default:              byte_sel = 8'd0;
    endcase
  end

  assign m_tvalid = busy;
  assign m_tdata  = {5'd0, (bad ? 8'd0 : byte_sel), idx};
  assign m_tlast  = at_last;
  assign m_tuser  = bad;

endmodule

// ----- rtl/fractional_divider_param_encoder.sv -----
// Top level of the fractional divider parameter encoder.
// Usage:
//   The slave side takes one divide ratio a + b/c per transaction. The master
//   side returns the eight bytes of the parameter block (P3 high, P3 low,
//   P1 top bits, P1 mid, P1 low, shared nibbles, P2 mid, P2 low), one byte per
//   transaction, with m_tlast on the eighth byte.
//   A row of seven division cells works out q = floor(128*b/c) one bit per
//   cell; the remainder leaving the last cell is P2. A ratio with c zero,
//   b not below c, or a below 4 gives eight zero bytes with m_tuser set.
// Timing:
//   An item passes through the seven division cells and is then registered in
//   the byte serializer, which sends one byte per cycle while m_tready is high
//   and takes the next item as the last byte of a block is accepted. While bytes
//   are going out, up to seven later items keep moving into the division cells.
// Reset and stalls:
//   rst clears all valid flags; no partial block survives it. When m_tready
//   is low the byte on the master side holds; once the item in the last
//   division cell has to wait, the whole row holds and s_tready drops.
module fractional_divider_param_encoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [10:0] whole_part, [30:11] numerator, [50:31] denominator, rest zero
  input  logic [fdpe_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [2:0] byte_offset, [10:3] byte_value, rest zero
  output logic [fdpe_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                 m_tlast,
  // [0] invalid
  output logic                                 m_tuser
);

  fdpe_pkg::div_stage_t stage [fdpe_pkg::QUO_W+1];

  logic [fdpe_pkg::WHOLE_W-1:0] whole;
  logic [fdpe_pkg::FRAC_W-1:0]  num;
  logic [fdpe_pkg::FRAC_W-1:0]  den;
  logic                         ser_ready;
  logic                         advance;

  assign whole = s_tdata[10:0];
  assign num   = s_tdata[30:11];
  assign den   = s_tdata[50:31];

  // The whole row moves together; it only stops when the tail item waits.
  assign advance  = !stage[fdpe_pkg::QUO_W].valid || ser_ready;
  assign s_tready = advance;

  always_comb begin
    stage[0].valid = s_tvalid;
    stage[0].bad   = (den == '0) || (num >= den) || (whole < fdpe_pkg::MIN_WHOLE);
    stage[0].whole = whole;
    stage[0].den   = den;
    stage[0].rem   = num;
    stage[0].quo   = '0;
  end

  for (genvar k = 0; k < fdpe_pkg::QUO_W; k++) begin : g_cell
    fdpe_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .stage_in  (stage[k]),
      .stage_out (stage[k+1])
    );
  end

  fdpe_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .stage_in (stage[fdpe_pkg::QUO_W]),
    .in_ready (ser_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- rtl/fdpe_checker.sv -----
// Port-level checks for the fractional divider parameter encoder, bound to the top level.
module fdpe_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [fdpe_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input logic                                 m_tlast,
  input logic                                 m_tuser
);

  a_last_on_final_offset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[2:0] == fdpe_pkg::OFS_P2_LO)))
    else $error("tlast does not match the final byte offset");

  a_offset_steps: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && (m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1)))
    else $error("byte offsets within a block are not consecutive");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[10:3] == 8'd0))
    else $error("invalid block carries a nonzero byte");

  a_invalid_per_block: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tuser == $past(m_tuser)))
    else $error("invalid flag changed inside a block");

endmodule

bind fractional_divider_param_encoder fdpe_checker u_fdpe_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the fractional divider parameter encoder.
module testbench;

  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 32;
  localparam int BLOCK_BYTES  = 8;

  // The eight register bytes of one parameter block, offset 0 first.
  typedef struct packed {
    logic            bad;
    logic [0:7][7:0] regs;
  } param_block_t;

  typedef struct packed {
    logic [fdpe_pkg::OFS_W-1:0]  ofs;
    logic [fdpe_pkg::BYTE_W-1:0] val;
    logic                        last;
    logic                        bad;
  } block_byte_t;

  typedef struct packed {
    logic [fdpe_pkg::WHOLE_W-1:0] whole;
    logic [fdpe_pkg::FRAC_W-1:0]  num;
    logic [fdpe_pkg::FRAC_W-1:0]  den;
    logic                         typed;
    param_block_t                 blk;
  } ratio_row_t;

  localparam param_block_t NO_BLOCK  = '0;
  localparam param_block_t BAD_BLOCK = {1'b1, 64'd0};

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [fdpe_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [fdpe_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tlast;
  logic                             m_tuser;

  block_byte_t pending_bytes[$];
  int          errors = 0;
  int          ratios_sent = 0;
  int          invalid_ratios = 0;
  int          bytes_checked = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic [8:0]  rx_cycle = '0;

  // Rows with a typed block are simple enough to read off by hand; the
  // others go through the encoder model below.
  ratio_row_t directed [0:20] = '{
    '{11'd4,    20'h00000, 20'h00001, 1'b1, {1'b0, 64'h0001_0000_0000_0000}},
    '{11'd2047, 20'h00000, 20'h00001, 1'b1, {1'b0, 64'h0001_03FD_8000_0000}},
    '{11'd4,    20'h00000, 20'hFFFFF, 1'b1, {1'b0, 64'hFFFF_0000_00F0_0000}},
    '{11'd100,  20'h00000, 20'h00000, 1'b1, BAD_BLOCK},
    '{11'd2047, 20'hFFFFF, 20'h00000, 1'b1, BAD_BLOCK},
    '{11'd10,   20'h00005, 20'h00005, 1'b1, BAD_BLOCK},
    '{11'd10,   20'hFFFFF, 20'hFFFFE, 1'b1, BAD_BLOCK},
    '{11'd3,    20'h00001, 20'h00002, 1'b1, BAD_BLOCK},
    '{11'd0,    20'h00000, 20'h00000, 1'b1, BAD_BLOCK},
    '{11'd3,    20'h00000, 20'h00001, 1'b1, BAD_BLOCK},
    '{11'd4,    20'hFFFFE, 20'hFFFFF, 1'b0, NO_BLOCK},
    '{11'd2047, 20'hFFFFE, 20'hFFFFF, 1'b0, NO_BLOCK},
    '{11'd5,    20'h00001, 20'h00003, 1'b0, NO_BLOCK},
    '{11'd1000, 20'd12345, 20'd54321, 1'b0, NO_BLOCK},
    '{11'd4,    20'h00001, 20'h00002, 1'b0, NO_BLOCK},
    '{11'd7,    20'h80000, 20'hFFFFF, 1'b0, NO_BLOCK},
    '{11'd2047, 20'h7FFFF, 20'h80000, 1'b0, NO_BLOCK},
    '{11'd1024, 20'h00000, 20'h55555, 1'b0, NO_BLOCK},
    '{11'h555,  20'h2AAAA, 20'hAAAAA, 1'b0, NO_BLOCK},
    '{11'h2AA,  20'h55555, 20'hAAAAA, 1'b0, NO_BLOCK},
    '{11'd1023, 20'h00003, 20'h00080, 1'b0, NO_BLOCK}
  };

  fractional_divider_param_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic param_block_t encode_ratio(logic [fdpe_pkg::WHOLE_W-1:0] whole,
                                                logic [fdpe_pkg::FRAC_W-1:0] num,
                                                logic [fdpe_pkg::FRAC_W-1:0] den);
    param_block_t                blk;
    logic [27:0]                 scaled;
    logic [fdpe_pkg::QUO_W-1:0]  quo;
    logic [fdpe_pkg::P1_W-1:0]   p1;
    logic [fdpe_pkg::FRAC_W-1:0] p2;
    logic [fdpe_pkg::FRAC_W-1:0] p3;
    blk.bad = (den == '0) || (num >= den) || (whole < fdpe_pkg::MIN_WHOLE);
    p1 = '0;
    p2 = '0;
    p3 = '0;
    if (!blk.bad) begin
      scaled = {1'b0, num, 7'd0};
      quo = fdpe_pkg::QUO_W'(scaled / {8'd0, den});
      p1 = {whole, 7'd0} + fdpe_pkg::P1_W'(quo) - fdpe_pkg::P1_BIAS;
      p2 = fdpe_pkg::FRAC_W'(scaled - {8'd0, den} * quo);
      p3 = den;
    end
    blk.regs[fdpe_pkg::OFS_P3_HI]  = p3[15:8];
    blk.regs[fdpe_pkg::OFS_P3_LO]  = p3[7:0];
    blk.regs[fdpe_pkg::OFS_P1_TOP] = {6'd0, p1[17:16]};
    blk.regs[fdpe_pkg::OFS_P1_MID] = p1[15:8];
    blk.regs[fdpe_pkg::OFS_P1_LO]  = p1[7:0];
    blk.regs[fdpe_pkg::OFS_NIBBLE] = {p3[19:16], p2[19:16]};
    blk.regs[fdpe_pkg::OFS_P2_MID] = p2[15:8];
    blk.regs[fdpe_pkg::OFS_P2_LO]  = p2[7:0];
    return blk;
  endfunction

  task automatic queue_block(param_block_t blk);
    block_byte_t b;
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      b.ofs  = fdpe_pkg::OFS_W'(k);
      b.val  = blk.regs[k];
      b.last = (b.ofs == fdpe_pkg::OFS_P2_LO);
      b.bad  = blk.bad;
      pending_bytes.push_back(b);
    end
  endtask

  // Bursts of random length; a gap, if any, is taken before the next burst.
  task automatic send_ratio(ratio_row_t row);
    param_block_t blk;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, row.den, row.num, row.whole};
    do @(posedge clk); while (!s_tready);
    blk = row.typed ? row.blk : encode_ratio(row.whole, row.num, row.den);
    queue_block(blk);
    ratios_sent++;
    if (blk.bad) invalid_ratios++;
  endtask

  task automatic drain_blocks();
    s_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Receiver: the top two bits of rx_cycle pick one of four stall patterns.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    case (rx_cycle[8:7])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_tready <= (rx_cycle[2:0] != 3'd5);
      default: m_tready <= (rx_cycle[3:0] >= 4'd12);
    endcase
  end

  always @(posedge clk) begin
    block_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        $error("byte with no block pending: tdata %h last %b user %b",
               m_tdata, m_tlast, m_tuser);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (m_tdata[2:0] !== want.ofs) begin
          $error("byte_offset: expected %0d, got %0d", want.ofs, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[10:3] !== want.val) begin
          $error("byte_value: expected %h, got %h", want.val, m_tdata[10:3]);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last_byte: expected %b, got %b", want.last, m_tlast);
          errors++;
        end
        if (m_tuser !== want.bad) begin
          $error("invalid: expected %b, got %b", want.bad, m_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    ratio_row_t row;
    int pick;
    int width;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_ratio(directed[i]);
    drain_blocks();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      row.typed = 1'b0;
      row.blk   = NO_BLOCK;
      row.whole = fdpe_pkg::WHOLE_W'($urandom_range(4, 2047));
      width     = $urandom_range(1, fdpe_pkg::FRAC_W);
      row.den   = fdpe_pkg::FRAC_W'($urandom) >> (fdpe_pkg::FRAC_W - width);
      if (row.den == '0) row.den = 20'd1;
      row.num   = fdpe_pkg::FRAC_W'($urandom_range(0, row.den - 1));
      // Most ratios are encodable; the rest break one rule or are pure noise.
      pick = $urandom_range(0, 9);
      case (pick)
        7: row.den = '0;
        8: begin
          row.num = fdpe_pkg::FRAC_W'($urandom);
          row.den = fdpe_pkg::FRAC_W'($urandom);
        end
        9: row.whole = fdpe_pkg::WHOLE_W'($urandom_range(0, 3));
        default: ;
      endcase
      send_ratio(row);
      if (n == RANDOM_ITEMS / 2) drain_blocks();
    end

    drain_blocks();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Encoded %0d ratios (%0d invalid) and compared %0d register bytes,",
             ratios_sent, invalid_ratios, bytes_checked);
    $display("with bursty input, full drains and four receiver stall patterns.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
